>>> rtl/escs_pkg.sv
// Package: shared types and constants of the event scheduler clock slicer.
package escs_pkg;

   localparam int ACTION_W   = 2;
   localparam int KIND_W     = 3;
   localparam int TIME_W     = 64;
   localparam int DELAY_W    = 32;
   localparam int HANDLER_W  = 8;
   localparam int PARAM_W    = 64;
   localparam int MAIN_W     = 8;
   localparam int HALF_W     = 8;
   localparam int SEVENTH_W  = 6;
   localparam int HREM_W     = 2;
   localparam int SREM_W     = 3;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 96;
   localparam int MAX_FIRE   = 16;

   localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SLICE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_SLICE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FIRED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADDED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FULL  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NONE  = 3'd4;

   localparam logic [TIME_W-1:0] IDLE_DUE = 64'h7FFF_FFFF_0000_0000;
   localparam logic [7:0] SLICE_LIMIT_RESET = 8'd64;

   // controller -> datapath commands
   typedef struct packed {
      logic load_req;    // capture the accepted transaction
      logic do_add;      // write slot, lower nearest due
      logic do_slice;    // commit slice counts
      logic do_advance;  // add pending counts
      logic scan_start;  // open the slot scan
      logic scan_step;   // look at one slot
      logic scan_done;   // commit the recomputed nearest due
      logic fire;        // clear the slot currently fired
   } escs_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic reached;     // main count has reached nearest due
      logic slot_due;    // current scanned slot fires
      logic last_slot;   // current scan index is the final slot
      logic have_free;   // a slot is free
   } escs_stat_type;

endpackage

>>> rtl/event_scheduler_clock_slicer_unit.sv
// Top level of the event scheduler clock slicer.
// One transaction at a time; a new request is taken the cycle after the
// final result of the previous one has been accepted. An add gives its
// result from the decode state; a slice goes on through a done state, and
// an advance that does not reach the nearest due time through a check
// state. An advance that reaches it scans every slot of a registered-read
// table, the scan holding while a result waits. Results of one advance
// form a run closed by tlast; a fired result is held back until the next
// due slot or the end of the scan is seen, so tlast is known when it is
// presented.
module event_scheduler_clock_slicer_unit #(
   parameter int EVENT_SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // action, delay_cycles, handler_id, event_param
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // main_slice, half_slice, seventh_slice, fired_handler,
                                     // fired_param, zero pad
   output logic [2:0]   rsp_tuser,   // result_kind
   output logic         rsp_tlast,   // last
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import escs_pkg::*;

   escs_cmd_type  cmd;
   escs_stat_type stat;
   logic [7:0] limit_ff;
   logic [2:0] kind, kind_s;
   logic last_i, fired;
   logic [7:0] ms, hs, fh;
   logic [5:0] ss;
   logic [63:0] fp;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {24'd0, limit_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) limit_ff <= SLICE_LIMIT_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         limit_ff <= csr_pwdata[7:0];
   end

   escs_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_action(req_tdata[1:0]),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_kind(kind), .rsp_last(last_i), .rsp_fired(fired),
      .cmd(cmd), .stat(stat)
   );

   escs_datapath #(.EVENT_SLOTS(EVENT_SLOTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_tdata(req_tdata), .slice_limit(limit_ff),
      .rsp_kind_slice(kind_s), .main_slice(ms), .half_slice(hs),
      .seventh_slice(ss), .fired_handler(fh), .fired_param(fp)
   );

   wire slice_out = (kind == kind_s) && !fired;
   assign rsp_tuser = kind;
   assign rsp_tlast = last_i;
   assign rsp_tdata = {2'b0, fired ? fp : 64'd0, fired ? fh : 8'd0,
                       slice_out ? ss : 6'd0, slice_out ? hs : 8'd0,
                       slice_out ? ms : 8'd0};

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accepting while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("result changed");
   a_added: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ADDED |-> rsp_tlast) else $error("add run");
endmodule

>>> rtl/escs_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module escs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

>>> rtl/escs_datapath.sv
// Datapath: counters, slice arithmetic, slot table and scan.
module escs_datapath #(
   parameter int EVENT_SLOTS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  escs_pkg::escs_cmd_type       cmd,
   output escs_pkg::escs_stat_type      stat,
   input  logic [111:0]                 req_tdata,
   input  logic [7:0]                   slice_limit,
   output logic [2:0]                   rsp_kind_slice,
   output logic [7:0]                   main_slice,
   output logic [7:0]                   half_slice,
   output logic [5:0]                   seventh_slice,
   output logic [7:0]                   fired_handler,
   output logic [63:0]                  fired_param
);
   import escs_pkg::*;

   localparam int IDX_W = $clog2(EVENT_SLOTS);
   localparam int SLOT_W = TIME_W + HANDLER_W + PARAM_W;
   localparam int FCNT_W = $clog2(MAX_FIRE + 1);

   logic [DELAY_W-1:0]   delay_ff;
   logic [HANDLER_W-1:0] handler_ff;
   logic [PARAM_W-1:0]   param_ff;
   logic [TIME_W-1:0] main_count_ff, half_count_ff, seventh_count_ff, nearest_ff, next_ff;
   logic [HREM_W-1:0] hrem_ff;
   logic [SREM_W-1:0] srem_ff;
   logic [MAIN_W-1:0] pm_ff;
   logic [HALF_W-1:0] ph_ff;
   logic [SEVENTH_W-1:0] ps_ff;
   logic [EVENT_SLOTS-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0] idx_ff, free_idx;
   logic [FCNT_W-1:0] fire_cnt_ff;
   logic             have_free;
   logic [TIME_W-1:0] due_sum, delta;
   logic [MAIN_W-1:0] m;
   logic [HALF_W-1:0] h;
   logic [SEVENTH_W-1:0] s, s7;
   logic [HREM_W-1:0] hr;
   logic [SREM_W:0]   sr;
   logic [2:0]        m7;
   logic [SLOT_W-1:0] rd;
   logic [IDX_W-1:0]  raddr;
   logic [TIME_W-1:0] rd_due, next_val;
   logic              rd_fire;

   // first free slot
   always_comb begin
      free_idx = '0;
      have_free = 1'b0;
      for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
            have_free = 1'b1;
         end
      end
   end

   assign due_sum = main_count_ff + TIME_W'(delay_ff);
   assign delta = nearest_ff - main_count_ff;
   assign m = (nearest_ff > main_count_ff) ?
              ((delta < TIME_W'(slice_limit)) ? delta[MAIN_W-1:0] : slice_limit) : '0;
   // m/7 by reciprocal: (m*293)>>11 is exact for m < 256
   assign s7 = SEVENTH_W'((19'(m) * 19'd293) >> 11);
   assign m7 = 3'(m - MAIN_W'(s7) * 8'd7);
   always_comb begin
      h = {1'b0, m[MAIN_W-1:1]};
      hr = hrem_ff + HREM_W'(m[0]);
      if (hr == 2'd2) begin
         h = h + 8'd1;
         hr = '0;
      end
      s = s7;
      sr = {1'b0, srem_ff} + {1'b0, m7};
      if (sr >= 4'd7) begin
         s = s + 6'd1;
         sr = sr - 4'd7;
      end
   end

   // slot memory: scan reads at idx, registered; raddr is idx + 1 on a scan step, 0 on scan start
   assign raddr = cmd.scan_start ? '0 : (cmd.scan_step ? idx_ff + IDX_W'(1) : idx_ff);
   escs_ram #(.WIDTH(SLOT_W), .DEPTH(EVENT_SLOTS)) u_slots (
      .clock(clock),
      .we(cmd.do_add && have_free),
      .waddr(free_idx),
      .wdata({due_sum, handler_ff, param_ff}),
      .raddr(raddr),
      .rdata(rd)
   );
   assign rd_due = rd[SLOT_W-1 -: TIME_W];
   // firing stops once MAX_FIRE events have gone in this advance
   assign rd_fire = valid_ff[idx_ff] && (rd_due <= nearest_ff) &&
                    (fire_cnt_ff < FCNT_W'(MAX_FIRE));
   // running minimum over slots that stay valid, current slot included
   assign next_val = (valid_ff[idx_ff] && !rd_fire && rd_due < next_ff) ? rd_due : next_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.do_add && have_free) valid_in[free_idx] = 1'b1;
      if (cmd.fire) valid_in[idx_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_count_ff <= '0; half_count_ff <= '0; seventh_count_ff <= '0;
         hrem_ff <= '0; srem_ff <= '0; nearest_ff <= '0;
         pm_ff <= '0; ph_ff <= '0; ps_ff <= '0;
         valid_ff <= '0; idx_ff <= '0; next_ff <= IDLE_DUE;
         fire_cnt_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.load_req) begin
            delay_ff <= req_tdata[ACTION_W +: DELAY_W];
            handler_ff <= req_tdata[ACTION_W+DELAY_W +: HANDLER_W];
            param_ff <= req_tdata[ACTION_W+DELAY_W+HANDLER_W +: PARAM_W];
         end
         if (cmd.do_add && have_free && due_sum < nearest_ff) nearest_ff <= due_sum;
         if (cmd.do_slice) begin
            pm_ff <= m; ph_ff <= h; ps_ff <= s;
            hrem_ff <= hr; srem_ff <= sr[SREM_W-1:0];
         end
         if (cmd.do_advance) begin
            main_count_ff <= main_count_ff + TIME_W'(pm_ff);
            half_count_ff <= half_count_ff + TIME_W'(ph_ff);
            seventh_count_ff <= seventh_count_ff + TIME_W'(ps_ff);
         end
         if (cmd.scan_start) begin
            idx_ff <= '0;
            next_ff <= IDLE_DUE;
            fire_cnt_ff <= '0;
         end else if (cmd.scan_step) begin
            next_ff <= next_val;
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.scan_done) nearest_ff <= next_val;
         if (cmd.fire) begin
            fired_handler <= rd[PARAM_W +: HANDLER_W];
            fired_param <= rd[PARAM_W-1:0];
            fire_cnt_ff <= fire_cnt_ff + FCNT_W'(1);
         end
      end
   end

   assign stat.reached   = main_count_ff >= nearest_ff;
   assign stat.slot_due  = rd_fire;
   assign stat.last_slot = (idx_ff == IDX_W'(EVENT_SLOTS - 1));
   assign stat.have_free = have_free;
   assign rsp_kind_slice = KIND_SLICE;
   assign main_slice = pm_ff;
   assign half_slice = ph_ff;
   assign seventh_slice = ps_ff;
endmodule

>>> rtl/escs_ctrl.sv
// Controller: sequences transactions, the slot scan and the result stream.
module escs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [1:0]              req_action,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [2:0]              rsp_kind,
   output logic                    rsp_last,
   output logic                    rsp_fired,
   output escs_pkg::escs_cmd_type  cmd,
   input  escs_pkg::escs_stat_type stat
);
   import escs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SCAN, S_HOLD, S_ADV_CHECK, S_DONE_OUT
   } state_type;

   state_type state_ff;
   logic [1:0] act_ff;
   logic [2:0] kind_ff;
   logic last_ff, valid_ff, held_ff;
   logic rsp_take;

   assign rsp_take = valid_ff && rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_last = last_ff;
   assign rsp_fired = (kind_ff == KIND_FIRED);

   always_comb begin
      cmd = '0;
      cmd.load_req = req_tvalid && req_tready;
      case (state_ff)
         S_DECODE: begin
            cmd.do_add = (act_ff == ACT_ADD);
            cmd.do_slice = (act_ff == ACT_SLICE);
            cmd.do_advance = (act_ff == ACT_ADVANCE);
         end
         S_ADV_CHECK: cmd.scan_start = stat.reached;
         S_SCAN: begin
            // scan stands still while a result waits and while a held fired result goes out
            if (!valid_ff && !(stat.slot_due && held_ff)) begin
               cmd.scan_step = !stat.last_slot;
               cmd.fire = stat.slot_due;
               cmd.scan_done = stat.last_slot;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         act_ff <= ACT_ADD;
         kind_ff <= KIND_SLICE;
         last_ff <= 1'b0;
         held_ff <= 1'b0;
      end else begin
         if (rsp_take) valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  act_ff <= req_action;
                  state_ff <= (req_action == ACT_UNUSED) ? S_IDLE : S_DECODE;
               end
            end
            S_DECODE: begin
               case (act_ff)
                  ACT_ADD: begin
                     kind_ff <= stat.have_free ? KIND_ADDED : KIND_FULL;
                     last_ff <= 1'b1; valid_ff <= 1'b1; state_ff <= S_IDLE;
                  end
                  ACT_SLICE: begin
                     state_ff <= S_DONE_OUT;
                  end
                  default: state_ff <= S_ADV_CHECK;
               endcase
            end
            S_DONE_OUT: begin
               kind_ff <= KIND_SLICE; last_ff <= 1'b1; valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_ADV_CHECK: begin
               held_ff <= 1'b0;
               if (stat.reached) begin
                  state_ff <= S_HOLD;
               end else begin
                  kind_ff <= KIND_NONE; last_ff <= 1'b1; valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_HOLD: state_ff <= S_SCAN; // RAM read latency
            S_SCAN: begin
               if (!valid_ff) begin
                  if (stat.slot_due && held_ff) begin
                     // another due slot follows: held result is not the last
                     kind_ff <= KIND_FIRED; last_ff <= 1'b0; valid_ff <= 1'b1;
                     held_ff <= 1'b0;
                  end else begin
                     if (stat.last_slot) held_ff <= 1'b0;
                     else if (stat.slot_due) held_ff <= 1'b1;
                     if (stat.last_slot) begin
                        kind_ff <= (stat.slot_due || held_ff) ? KIND_FIRED : KIND_NONE;
                        last_ff <= 1'b1; valid_ff <= 1'b1;
                        state_ff <= S_IDLE;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
